// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

// A next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- hdl/sce_pkg.sv -----
// ---------------------------------------------------------------------------
// Spectrum column envelope package
// Sizes, constants, the column tracking bundle and the height mapping.
// ---------------------------------------------------------------------------
package sce_pkg;

	localparam int BINS    = 16384;
	localparam int COLUMNS = 800;

	localparam int BIN_W  = $clog2(BINS);
	localparam int ACC_W  = BIN_W + 1;
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int LVL_W  = 13;
	localparam int H_W    = 10;
	localparam int ROW_W  = 10;
	localparam int DISP_W = 10;

	localparam int HALF_COLUMNS = COLUMNS / 2;
	localparam int LAST_DISP    = (COLUMNS - 1 + HALF_COLUMNS) % COLUMNS;

	localparam logic [H_W-1:0]    H_CLAMP      = H_W'(599);
	localparam logic signed [13:0] DB_OFFSET_Q4 = 14'sd2400;

	typedef struct packed {
		logic              col_end;
		logic              frame_end;
		logic [DISP_W-1:0] disp;
	} col_info_t;

	// Height in quarter dB above -150 dB, clamped to 0..599.
	function automatic logic [H_W-1:0] height_of(input logic signed [LVL_W-1:0] level);
		logic signed [13:0] sum;
		logic [11:0]        quarter;
		sum     = $signed({level[LVL_W-1], level}) + DB_OFFSET_Q4;
		quarter = sum[13:2];
		if (sum[13]) begin
			return '0;
		end else if (quarter > 12'(H_CLAMP)) begin
			return H_CLAMP;
		end else begin
			return quarter[H_W-1:0];
		end
	endfunction

endpackage

// ----- hdl/spectrum_column_envelope.sv -----
// ---------------------------------------------------------------------------
// Spectrum column envelope
// Maps each bin level to a height, keeps the min and max height of the
// current screen column and emits one vertical span per column.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid, in_stall   | level_db
//  out     | out_valid, out_stall | display_column, top_row, end_row, frame_last
//
// One bin is taken per cycle unless stalled; a column's last bin triggers its span.
// The input register and the result register are the only pipeline stages.
// The input stalls only while the input register holds a bin and the
// result register is full and stalled. Reset clears the bin count and the
// column extremes; no result is pending after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_column_envelope
	import sce_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [LVL_W-1:0] level_db,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DISP_W-1:0]       display_column,
	output logic [ROW_W-1:0]        top_row,
	output logic [ROW_W-1:0]        end_row,
	output logic                    frame_last
);

	logic                    valid_s1;
	logic signed [LVL_W-1:0] level_s1;
	logic                    out_free;
	logic                    advance;
	col_info_t               info;
	logic [H_W-1:0]          height;
	logic [H_W-1:0]          max_q;
	logic [H_W-1:0]          min_q;
	logic [H_W-1:0]          new_max;
	logic [H_W-1:0]          new_min;
	logic [H_W-1:0]          span_min;
	logic                    out_valid_q;
	logic [DISP_W-1:0]       disp_q;
	logic [ROW_W-1:0]        top_q;
	logic [ROW_W-1:0]        end_q;
	logic                    last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= level_db;
		end
	end

	sce_col_track u_col_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.info    (info)
	);

	always_comb begin
		height   = height_of(level_s1);
		new_max  = (height > max_q) ? height : max_q;
		new_min  = (min_q == '0 || height < min_q) ? height : min_q;
		span_min = (new_min == new_max) ? '0 : new_min;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			min_q <= '0;
		end else if (advance) begin
			if (info.col_end) begin
				max_q <= '0;
				min_q <= '0;
			end else begin
				max_q <= new_max;
				min_q <= new_min;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && info.col_end;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && info.col_end) begin
			disp_q <= info.disp;
			top_q  <= ROW_W'(H_CLAMP - new_max);
			end_q  <= ROW_W'(H_CLAMP - span_min);
			last_q <= info.frame_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign display_column = disp_q;
	assign top_row        = top_q;
	assign end_row        = end_q;
	assign frame_last     = last_q;

	`ASSERT_IMP(a_span_order, out_valid_q, end_q >= top_q, "span end above span top")
	`ASSERT_IMP(a_last_column, out_valid_q && last_q, 32'(disp_q) == LAST_DISP,
		"frame end on wrong column")
	`ASSERT_CLK(a_height_range, max_q <= H_CLAMP && min_q <= max_q,
		"column extremes out of order")

endmodule

// ----- hdl/sce_col_track.sv -----
// ---------------------------------------------------------------------------
// Column tracker
// Follows the bin index, its screen column and the column boundary by a
// running remainder of bin * COLUMNS, and gives the rotated screen column.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sce_col_track
	import sce_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	output col_info_t info
);

	logic [BIN_W-1:0]  bin_q;
	logic [BIN_W-1:0]  acc_q;
	logic [COL_W-1:0]  col_q;
	logic [ACC_W-1:0]  acc_sum;
	logic              wrap;
	logic [COL_W:0]    disp_sum;
	logic [DISP_W-1:0] disp;

	assign acc_sum        = ACC_W'(acc_q) + ACC_W'(COLUMNS);
	assign wrap           = acc_sum >= ACC_W'(BINS);
	assign info.frame_end = bin_q == BIN_W'(BINS - 1);
	assign info.col_end   = info.frame_end | wrap;
	assign info.disp      = disp;
	assign disp_sum       = (COL_W + 1)'(col_q) + (COL_W + 1)'(HALF_COLUMNS);

	always_comb begin
		if (disp_sum >= (COL_W + 1)'(COLUMNS)) begin
			disp = DISP_W'(disp_sum - (COL_W + 1)'(COLUMNS));
		end else begin
			disp = DISP_W'(disp_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			acc_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			if (info.frame_end) begin
				bin_q <= '0;
				acc_q <= '0;
				col_q <= '0;
			end else begin
				bin_q <= bin_q + BIN_W'(1);
				if (wrap) begin
					acc_q <= BIN_W'(acc_sum - ACC_W'(BINS));
					col_q <= col_q + COL_W'(1);
				end else begin
					acc_q <= BIN_W'(acc_sum);
				end
			end
		end
	end

	`ASSERT_CLK(a_acc_range, ACC_W'(acc_q) < ACC_W'(BINS), "remainder out of range")
	`ASSERT_CLK(a_col_range, 32'(col_q) < COLUMNS, "column out of range")
	`ASSERT_IMP(a_frame_start, bin_q == '0, acc_q == '0 && col_q == '0, "frame start not aligned")

endmodule

// ----- dv/tb_spectrum_column_envelope.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Spectrum column envelope testbench
// Streams bin levels through the block and predicts the span of every
// finished column from its own copy of the bin count and column extremes.
// Each span is checked field by field against the oldest prediction, with
// random idle bursts on both channels, one long output hold-off and a pause
// that lets the block drain. The first column carries the level corners.
// ---------------------------------------------------------------------------

module tb_spectrum_column_envelope
	import sce_pkg::*;
();

	localparam int OFFSET_QDB    = 2400;
	localparam int TOP_HEIGHT    = 599;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int TAIL_ITEMS    = 300;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 10;
	localparam int WATCHDOG_MAX  = 3000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		logic signed [LVL_W-1:0] level;
		bit                      drain_first;
	} bin_item_t;

	typedef struct packed {
		logic [DISP_W-1:0] disp_col;
		logic [ROW_W-1:0]  top_row;
		logic [ROW_W-1:0]  end_row;
		logic              frame_last;
	} column_span_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [LVL_W-1:0] level_db = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [DISP_W-1:0]       display_column;
	logic [ROW_W-1:0]        top_row;
	logic [ROW_W-1:0]        end_row;
	logic                    frame_last;

	bin_item_t    pending_bins[$];
	column_span_t span_queue[$];
	bin_item_t    next_item;

	int next_bin = 0;
	int col_hi = 0;
	int col_lo = 0;
	int error_count = 0;

	int send_gap = 0;
	int send_calm = 0;
	int take_gap = 0;
	int take_calm = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int spans_seen = 0;
	int idle_cycles = 0;

	int gen_bin = 0;
	int random_count = 0;
	int mode = 0;
	logic signed [LVL_W-1:0] flat_level = '0;
	logic signed [LVL_W-1:0] level_pick;

	int corner_levels[21] = '{-4096, 4095, 0, -1, -4, -5, -2400, -2397, -2396, -2401,
		-2403, -2404, -2000, 100, -3000, 2000, -1200, -1201, -1199, -600, -2398};

	spectrum_column_envelope DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.level_db       (level_db),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.display_column (display_column),
		.top_row        (top_row),
		.end_row        (end_row),
		.frame_last     (frame_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int column_of_bin(input int bin);
		return int'((longint'(bin) * COLUMNS) / BINS);
	endfunction

	function automatic logic signed [LVL_W-1:0] level_between(input int lo, input int hi);
		return LVL_W'(lo + int'($urandom_range(hi - lo)));
	endfunction

	function automatic void queue_level(input logic signed [LVL_W-1:0] level,
			input bit drain_first);
		bin_item_t item;
		item.level = level;
		item.drain_first = drain_first;
		pending_bins.push_back(item);
		gen_bin = (gen_bin == BINS - 1) ? 0 : gen_bin + 1;
	endfunction

	task automatic record_bin(input logic signed [LVL_W-1:0] level);
		int height;
		int sum;
		int column;
		int lo;
		bit frame_end;
		bit column_end;
		column_span_t span;
		sum = int'(level) + OFFSET_QDB;
		height = (sum < 0) ? 0 : (sum >>> 2);
		if (height > TOP_HEIGHT) begin
			height = TOP_HEIGHT;
		end
		column = column_of_bin(next_bin);
		if (height > col_hi) begin
			col_hi = height;
		end
		if (col_lo == 0 || height < col_lo) begin
			col_lo = height;
		end
		frame_end = (next_bin == BINS - 1);
		column_end = frame_end || (column_of_bin(next_bin + 1) != column);
		next_bin = frame_end ? 0 : next_bin + 1;
		if (column_end) begin
			lo = (col_lo == col_hi) ? 0 : col_lo;
			span.disp_col = DISP_W'((column + COLUMNS / 2) % COLUMNS);
			span.top_row = ROW_W'(TOP_HEIGHT - col_hi);
			span.end_row = ROW_W'(TOP_HEIGHT - lo);
			span.frame_last = frame_end;
			span_queue.push_back(span);
			col_hi = 0;
			col_lo = 0;
		end
	endtask

	task automatic check_span();
		column_span_t want;
		column_span_t got;
		got = '{display_column, top_row, end_row, frame_last};
		if (span_queue.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_MAX) begin
				$display("%0t: unexpected span col=%0d top=%0d end=%0d last=%0b", $realtime,
					got.disp_col, got.top_row, got.end_row, got.frame_last);
			end
		end else begin
			want = span_queue.pop_front();
			if (got != want) begin
				error_count++;
				if (error_count <= REPORT_MAX) begin
					$display("%0t: span mismatch expected col=%0d top=%0d end=%0d last=%0b",
						$realtime, want.disp_col, want.top_row, want.end_row,
						want.frame_last);
					$display("%0t:                 actual col=%0d top=%0d end=%0d last=%0b",
						$realtime, got.disp_col, got.top_row, got.end_row, got.frame_last);
				end
			end
		end
	endtask

	// Sender: offers queued bins, with idle bursts outside quiet stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			level_db <= '0;
			send_gap <= 0;
			send_calm <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				record_bin(level_db);
			end
			if (send_calm != 0) begin
				send_calm <= send_calm - 1;
			end else if ($urandom_range(199) == 0) begin
				send_calm <= $urandom_range(150, 30);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bins.size() == 0 ||
						(pending_bins[0].drain_first && span_queue.size() != 0)) begin
					in_valid <= 1'b0;
				end else if (send_calm == 0 && hold_left == 0 &&
						pending_bins.size() >= TAIL_ITEMS && $urandom_range(9) == 0) begin
					send_gap <= $urandom_range(16);
					in_valid <= 1'b0;
				end else begin
					next_item = pending_bins.pop_front();
					in_valid <= 1'b1;
					level_db <= next_item.level;
				end
			end
		end
	end

	// Receiver: checks spans, stalls in bursts and once for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			take_gap <= 0;
			take_calm <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			spans_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_span();
				spans_seen <= spans_seen + 1;
			end
			if (take_calm != 0) begin
				take_calm <= take_calm - 1;
			end else if ($urandom_range(199) == 0) begin
				take_calm <= $urandom_range(150, 30);
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= (hold_left != 1);
			end else if (!hold_done && spans_seen >= 40) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				out_stall <= 1'b1;
			end else if (take_gap != 0) begin
				take_gap <= take_gap - 1;
				out_stall <= 1'b1;
			end else if (take_calm == 0 && pending_bins.size() >= TAIL_ITEMS &&
					$urandom_range(7) == 0) begin
				take_gap <= $urandom_range(16);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// The first column holds the field extremes, the height clamp edges and
		// zero heights that a later bin must replace as the minimum.
		foreach (corner_levels[i]) begin
			queue_level(LVL_W'(corner_levels[i]), 1'b0);
		end
		while (random_count < RANDOM_ITEMS) begin
			if (gen_bin == 0 || column_of_bin(gen_bin) != column_of_bin(gen_bin - 1)) begin
				mode = $urandom_range(4);
				flat_level = level_between(-2410, 10);
			end
			case (mode)
				0: level_pick = level_between(-2410, 10);
				1: level_pick = flat_level;
				2: level_pick = LVL_W'($urandom);
				3: level_pick = level_between(-2420, -2385);
				default: level_pick = level_between(-24, 16);
			endcase
			if (mode != 1 && $urandom_range(15) == 0) begin
				level_pick = LVL_W'($urandom);
			end
			queue_level(level_pick, random_count == 500 || random_count == 1200);
			random_count++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
		end while (pending_bins.size() != 0 || in_valid || span_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && span_queue.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
